FILE: design/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants for the LRU block cache tracker.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int BLOCK_W = 32;
    localparam int COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [COUNT_W-1:0] count_t;

    // broadcast from the lookup stage to every entry
    typedef struct packed {
        logic   update;
        logic   hit;
        block_t block;
    } lbc_cmd_t;

    // per-entry status back to the lookup stage
    typedef struct packed {
        logic   match;
        logic   lru;
        logic   valid;
        block_t tag;
    } lbc_stat_t;

endpackage

FILE: design/lbc_cell.sv
// ----------------------------------------------------------------------------
// lbc_cell
// One cache entry: tag, valid bit, recency rank, tag compare and rank update.
// ----------------------------------------------------------------------------
module lbc_cell
    import lbc_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int INDEX   = 0,
    localparam int RANK_W = $clog2(ENTRIES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lbc_cmd_t          cmd,
    input  logic [RANK_W-1:0] promote_rank,
    output lbc_stat_t         stat,
    output logic [RANK_W-1:0] rank
);

    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(ENTRIES - 1);
    localparam logic [RANK_W-1:0] RANK_INIT = RANK_W'(ENTRIES - 1 - INDEX);

    block_t            tag_reg;
    block_t            tag_next;
    logic              valid_reg;
    logic              valid_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    logic              sel;

    assign stat.match = valid_reg && (tag_reg == cmd.block);
    assign stat.lru   = (rank_reg == RANK_LAST);
    assign stat.valid = valid_reg;
    assign stat.tag   = tag_reg;
    assign rank       = rank_reg;

    assign sel = cmd.hit ? stat.match : stat.lru;

    always_comb begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.update) begin
            if (sel) begin
                rank_next = '0;
                if (!cmd.hit) begin
                    tag_next   = cmd.block;
                    valid_next = 1'b1;
                end
            end else if (rank_reg < promote_rank) begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= RANK_INIT;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
    end

endmodule

FILE: design/lbc_stats.sv
// ----------------------------------------------------------------------------
// lbc_stats
// Saturating hit and miss counters.
// ----------------------------------------------------------------------------
module lbc_stats
    import lbc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   update,
    input  logic   hit,
    output count_t hit_total,
    output count_t miss_total
);

    count_t hit_count_reg;
    count_t hit_count_next;
    count_t miss_count_reg;
    count_t miss_count_next;

    always_comb begin
        hit_count_next  = hit_count_reg;
        miss_count_next = miss_count_reg;
        if (update) begin
            if (hit) begin
                if (hit_count_reg != COUNT_MAX) begin
                    hit_count_next = hit_count_reg + COUNT_W'(1);
                end
            end else begin
                if (miss_count_reg != COUNT_MAX) begin
                    miss_count_next = miss_count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
        end else begin
            hit_count_reg  <= hit_count_next;
            miss_count_reg <= miss_count_next;
        end
    end

    assign hit_total  = hit_count_reg;
    assign miss_total = miss_count_reg;

endmodule

FILE: design/lru_block_cache_tracker.sv
// ----------------------------------------------------------------------------
// lru_block_cache_tracker
// Fully associative block cache with least-recently-used replacement.
//
// Input channel (s_): one beat carries one block number reference.
// Result channel (m_): one beat per reference with the hit flag, the block
// displaced on a miss (zero when none) and the saturating hit and miss
// totals including this reference.
// A beat is captured into an input register; once the result register is free
// or being read, all entries compare their tags in parallel, ranks are updated
// and the result register loads. Throughput is one reference per cycle while
// the receiver does not stall, set by the combinational tag match and rank
// update logic across all ENTRIES entries.
// When the receiver stalls, the result register holds and the input register
// holds one further beat; s_ready drops only when both are full.
// Reset empties every entry, sets entry i to rank ENTRIES-1-i (entry 0 fills
// first) and clears both totals. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_block_cache_tracker
    import lbc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  block_t s_block_number,
    output logic   m_valid,
    input  logic   m_ready,
    output logic   m_hit,
    output logic   m_evicted_valid,
    output block_t m_evicted_block,
    output count_t m_hit_total,
    output count_t m_miss_total
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(ENTRIES - 1);

    logic              in_valid_reg;
    logic              in_valid_next;
    block_t            in_block_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              hit_reg;
    logic              ev_valid_reg;
    block_t            ev_block_reg;
    logic              advance;
    logic              lookup_hit;
    logic              victim_valid;
    block_t            victim_tag;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] promote_rank;
    lbc_cmd_t          cmd;
    lbc_stat_t         stat [ENTRIES];
    logic [RANK_W-1:0] rank [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] lru_vec;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign cmd.update = advance;
    assign cmd.hit    = lookup_hit;
    assign cmd.block  = in_block_reg;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            lbc_cell #(
                .ENTRIES (ENTRIES),
                .INDEX   (gi)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .cmd          (cmd),
                .promote_rank (promote_rank),
                .stat         (stat[gi]),
                .rank         (rank[gi])
            );
            assign match_vec[gi] = stat[gi].match;
            assign lru_vec[gi]   = stat[gi].lru;
        end
    endgenerate

    always_comb begin
        hit_rank     = '0;
        victim_valid = 1'b0;
        victim_tag   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_rank     = hit_rank | (rank[i] & {RANK_W{stat[i].match}});
            victim_valid = victim_valid | (stat[i].lru & stat[i].valid);
            victim_tag   = victim_tag |
                           (stat[i].tag & {BLOCK_W{stat[i].lru & stat[i].valid}});
        end
    end

    assign lookup_hit   = |match_vec;
    assign promote_rank = lookup_hit ? hit_rank : RANK_LAST;

    lbc_stats u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .hit        (lookup_hit),
        .hit_total  (m_hit_total),
        .miss_total (m_miss_total)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_block_reg <= s_block_number;
        end
        if (advance) begin
            hit_reg      <= lookup_hit;
            ev_valid_reg <= !lookup_hit && victim_valid;
            ev_block_reg <= lookup_hit ? '0 : victim_tag;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hit           = hit_reg;
    assign m_evicted_valid = ev_valid_reg;
    assign m_evicted_block = ev_block_reg;

    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> $onehot0(match_vec))
        else $error("more than one entry matches the block");

    a_lru_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(lru_vec))
        else $error("least recent entry not unique");

    a_result_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result not presented after lookup");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (!m_evicted_valid && (m_evicted_block == '0)))
        else $error("eviction reported on a hit");

endmodule

FILE: dv/lru_block_cache_tracker_test.sv
// ----------------------------------------------------------------------------
// lru_block_cache_tracker_test
// Self-checking bench for the LRU block cache tracker. A short directed
// table exercises the all-ones and zero blocks, repeated hits on the most
// recent entry and hits deeper in the recency order. Random references
// follow, drawn from a hot set, a wider set that forces evictions, and fully
// random blocks. Every result beat is compared field by field against an
// in-bench LRU cache predictor. Random idle bursts land on both channels,
// except in the closing stretch.
// ----------------------------------------------------------------------------
module lru_block_cache_tracker_test
    import lbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 64;
    localparam int RANK_W     = $clog2(ENTRIES);
    localparam int NUM_PROBES = 19;
    localparam int NUM_RANDOM = 1230;
    localparam int TAIL_LEN   = 200;
    localparam int POOL_SIZE  = 160;
    localparam int HOT_SIZE   = 48;

    typedef struct packed {
        logic   hit;
        logic   ev_valid;
        block_t ev_block;
        count_t hits;
        count_t misses;
    } access_result_t;

    typedef struct packed {
        block_t         blk;
        logic           fixed;
        access_result_t res;
    } probe_row_t;

    logic   aclk           = 1'b0;
    logic   aresetn        = 1'b0;
    logic   s_valid        = 1'b0;
    logic   s_ready;
    block_t s_block_number = '0;
    logic   m_valid;
    logic   m_ready        = 1'b0;
    logic   m_hit;
    logic   m_evicted_valid;
    block_t m_evicted_block;
    count_t m_hit_total;
    count_t m_miss_total;

    block_t             line_tag   [ENTRIES];
    logic               line_valid [ENTRIES];
    logic [RANK_W-1:0]  line_rank  [ENTRIES];
    count_t             hit_count;
    count_t             miss_count;

    access_result_t expected_results [$];
    probe_row_t     probe_rows [NUM_PROBES];
    block_t         block_pool [POOL_SIZE];
    int             mismatches = 0;
    bit             tx_idle_on = 1'b0;
    bit             rx_idle_on = 1'b0;
    int             rx_stall_left = 0;

    lru_block_cache_tracker #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_block_number (s_block_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_evicted_valid(m_evicted_valid),
        .m_evicted_block(m_evicted_block),
        .m_hit_total    (m_hit_total),
        .m_miss_total   (m_miss_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2ms;
        $display("lru_block_cache_tracker_test: FAIL");
        $finish;
    end

    function automatic void clear_cache();
        for (int k = 0; k < ENTRIES; k++) begin
            line_tag[k]   = '0;
            line_valid[k] = 1'b0;
            line_rank[k]  = RANK_W'(ENTRIES - 1 - k);
        end
        hit_count  = '0;
        miss_count = '0;
    endfunction

    function automatic access_result_t predict_access(input block_t b);
        access_result_t r;
        int slot;
        int old;
        r    = '0;
        slot = -1;
        for (int k = 0; k < ENTRIES; k++) begin
            if (slot < 0 && line_valid[k] && line_tag[k] == b) slot = k;
        end
        if (slot >= 0) begin
            r.hit = 1'b1;
            if (hit_count != COUNT_MAX) hit_count = hit_count + COUNT_W'(1);
        end else begin
            for (int k = 0; k < ENTRIES; k++) begin
                if (int'(line_rank[k]) == ENTRIES - 1) slot = k;
            end
            if (miss_count != COUNT_MAX) miss_count = miss_count + COUNT_W'(1);
            if (line_valid[slot]) begin
                r.ev_valid = 1'b1;
                r.ev_block = line_tag[slot];
            end
            line_tag[slot]   = b;
            line_valid[slot] = 1'b1;
        end
        old = int'(line_rank[slot]);
        for (int k = 0; k < ENTRIES; k++) begin
            if (int'(line_rank[k]) < old) line_rank[k] = line_rank[k] + RANK_W'(1);
        end
        line_rank[slot] = '0;
        r.hits   = hit_count;
        r.misses = miss_count;
        return r;
    endfunction

    task automatic push_block(input block_t b, input logic fixed, input access_result_t typed);
        access_result_t r;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_block_number <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = predict_access(b);
        expected_results.push_back(fixed ? typed : r);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn || !rx_idle_on) begin
            m_ready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            rx_stall_left = $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        access_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(m_hit));
                check_field("evicted_valid", 32'(want.ev_valid), 32'(m_evicted_valid));
                check_field("evicted_block", want.ev_block, m_evicted_block);
                check_field("hit_total", want.hits, m_hit_total);
                check_field("miss_total", want.misses, m_miss_total);
            end
        end
    end

    initial begin
        block_t b;
        int     pick;
        bit     tail;

        probe_rows = '{
            '{32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd0, 32'd1}},
            '{32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 32'h0, 32'd1, 32'd1}},
            '{32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd1, 32'd2}},
            '{32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'h0, 32'd2, 32'd2}},
            '{32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 32'h0, 32'd3, 32'd2}},
            '{32'hAAAA_AAAA, 1'b0, '0},
            '{32'h5555_5555, 1'b0, '0},
            '{32'h0000_0001, 1'b0, '0},
            '{32'h8000_0000, 1'b0, '0},
            '{32'h7FFF_FFFF, 1'b0, '0},
            '{32'hFFFF_FFFE, 1'b0, '0},
            '{32'hAAAA_AAAA, 1'b0, '0},
            '{32'h0000_0000, 1'b0, '0},
            '{32'h1234_5678, 1'b0, '0},
            '{32'h0000_FFFF, 1'b0, '0},
            '{32'hFFFF_0000, 1'b0, '0},
            '{32'h5555_5555, 1'b0, '0},
            '{32'h8000_0000, 1'b0, '0},
            '{32'hFFFF_FFFF, 1'b0, '0}
        };
        block_pool[0] = '0;
        block_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) block_pool[k] = $urandom();

        clear_cache();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rx_idle_on = 1'b1;
        for (int k = 0; k < NUM_PROBES; k++) begin
            push_block(probe_rows[k].blk, probe_rows[k].fixed, probe_rows[k].res);
        end
        drain_results();

        for (int k = 0; k < NUM_RANDOM; k++) begin
            tail       = (k >= NUM_RANDOM - TAIL_LEN);
            tx_idle_on = !tail && ((k / 100) % 3 != 2);
            rx_idle_on = !tail && ((k / 100) % 3 != 1);
            pick = $urandom_range(0, 99);
            if (pick < 50) b = block_pool[$urandom_range(0, HOT_SIZE - 1)];
            else if (pick < 85) b = block_pool[$urandom_range(0, POOL_SIZE - 1)];
            else b = $urandom();
            push_block(b, 1'b0, '0);
            if (k == NUM_RANDOM / 2) drain_results();
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("lru_block_cache_tracker_test: PASS");
        end else begin
            $display("lru_block_cache_tracker_test: FAIL");
        end
        $finish;
    end

endmodule
